/* src/bll_pkg.sv */
// bll_pkg: types, codes and character tables shared by the line lexer core and top level
// no dependencies
package bll_pkg;

    // lexer modes, one-hot
    typedef enum logic [11:0] {
        MODE_IDLE    = 12'h001,
        MODE_ZERO    = 12'h002,
        MODE_HEXPRE  = 12'h004,
        MODE_HEX     = 12'h008,
        MODE_BINPRE  = 12'h010,
        MODE_BIN     = 12'h020,
        MODE_DEC     = 12'h040,
        MODE_STR     = 12'h080,
        MODE_IDENT   = 12'h100,
        MODE_OPER    = 12'h200,
        MODE_COMMENT = 12'h400,
        MODE_SKIP    = 12'h800
    } lex_mode_t;

    typedef enum logic [3:0] {
        KIND_NUM   = 4'd0,
        KIND_STR   = 4'd1,
        KIND_OP    = 4'd2,
        KIND_PLUS  = 4'd3,
        KIND_COMMA = 4'd4,
        KIND_OPEN  = 4'd5,
        KIND_CLOSE = 4'd6,
        KIND_VAR   = 4'd7,
        KIND_KW    = 4'd8,
        KIND_LABEL = 4'd9,
        KIND_EOL   = 4'd10,
        KIND_ERR   = 4'd11
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_INVALID = 3'd1,
        ERR_UNTERM  = 3'd2,
        ERR_LONG    = 3'd3,
        ERR_COUNT   = 3'd4
    } error_code_t;

    localparam int          KW_COUNT = 9;
    localparam logic [8:0]  KW_ALL   = 9'h1FF;
    localparam logic [3:0]  KW_ZERO  = 4'd0;

    // keyword text, right-justified, first character at the highest used byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("PRINT"), 64'("VAR"), 64'("INT8"), 64'("UINT8"), 64'("IF"),
        64'("THEN"), 64'("ELSE"), 64'("END"), 64'("MEMPEEK")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd4, 3'd3, 3'd7
    };

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        token_kind_t kind;
        logic [8:0]  start_col;
        logic [8:0]  end_col;
        logic [3:0]  keyword_index;
        error_code_t error_code;
        logic        last;
    } result_t;

    // results produced by one accepted character
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["A":"Z"], ["a":"z"], "_"};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {["0":"9"], ["A":"F"], ["a":"f"]};
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c inside {"(", ")", "[", "]", "=", "+", "-", "*", "/", ":", "&", "|",
                         "!", ","};
    endfunction

    function automatic token_kind_t single_op_kind(input logic [7:0] c);
        token_kind_t k;
        case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_COMMA: k = KIND_COMMA;
            CH_LBRK:  k = KIND_OPEN;
            CH_RBRK:  k = KIND_CLOSE;
            default:  k = KIND_OP;
        endcase
        return k;
    endfunction

    // character of keyword k at position pos, zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
        logic [63:0] text;
        logic [2:0]  len;
        logic [2:0]  sh;
        text = KW_TEXT[k];
        len  = KW_LEN[k];
        sh   = len - 3'd1 - pos;
        return (pos >= len) ? 8'h00 : text[{sh, 3'b000} +: 8];
    endfunction

endpackage

/* src/bll_core.sv */
// bll_core: lexer state registers and the per-character step logic
// depends on bll_pkg
module bll_core #(
    parameter int LINE_LEN   = 256,
    parameter int MAX_TOKENS = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      char_in,
    output bll_pkg::push_t  push
);

    localparam int CW = $clog2(LINE_LEN + 1);
    localparam int TW = $clog2(MAX_TOKENS + 1);

    bll_pkg::lex_mode_t mode_reg, mode_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [CW-1:0]      start_reg, start_next;
    logic [8:0]         cand_reg, cand_next;
    logic [7:0]         pend_reg, pend_next;
    logic [TW-1:0]      cnt_reg, cnt_next;

    function automatic bll_pkg::result_t make_res(
        input bll_pkg::token_kind_t kind,
        input logic [CW-1:0]        s,
        input logic [CW-1:0]        e,
        input logic [3:0]           kw,
        input bll_pkg::error_code_t err
    );
        bll_pkg::result_t r;
        r.kind          = kind;
        r.start_col     = 9'(s);
        r.end_col       = 9'(e);
        r.keyword_index = kw;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic logic [8:0] narrow(input logic [8:0] mask, input logic [CW-1:0] pos,
                                          input logic [7:0] c);
        logic [8:0] m;
        m = mask;
        for (int k = 0; k < bll_pkg::KW_COUNT; k++) begin
            if (pos >= CW'(8) || bll_pkg::kw_char(4'(k), pos[2:0]) != c) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    logic [CW-1:0] id_len;
    logic          kw_hit;
    logic [3:0]    kw_idx;

    // keyword match of the identifier collected so far
    always_comb begin
        id_len = col_reg - start_reg;
        kw_hit = 1'b0;
        kw_idx = bll_pkg::KW_ZERO;
        for (int k = bll_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (cand_reg[k] && id_len == CW'(bll_pkg::KW_LEN[k])) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    logic                 is_eol, cnt_full, cnt_a_full;
    logic                 a_valid, a_tok, a_fail, go_idle, pass_on;
    bll_pkg::token_kind_t a_kind;
    logic [CW-1:0]        a_s, a_e;
    logic [3:0]           a_kw;
    bll_pkg::error_code_t a_err;
    logic                 b_valid, b_tok;
    bll_pkg::token_kind_t b_kind;
    logic [CW-1:0]        b_s, b_e;
    logic [3:0]           b_kw;
    bll_pkg::error_code_t b_err;
    logic [TW-1:0]        cnt_a;
    bll_pkg::result_t     res_a, res_b;

    always_comb begin
        mode_next  = mode_reg;
        col_next   = col_reg;
        start_next = start_reg;
        cand_next  = cand_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        is_eol     = (char_in == bll_pkg::CH_NL) || (char_in == bll_pkg::CH_NUL);
        cnt_full   = cnt_reg >= TW'(MAX_TOKENS);
        a_valid = 1'b0; a_tok = 1'b0; a_fail = 1'b0; go_idle = 1'b0; pass_on = 1'b0;
        a_kind  = bll_pkg::KIND_NUM;
        a_s     = start_reg;
        a_e     = col_reg;
        a_kw    = bll_pkg::KW_ZERO;
        a_err   = bll_pkg::ERR_NONE;
        b_valid = 1'b0; b_tok = 1'b0;
        b_kind  = bll_pkg::KIND_NUM;
        b_s     = col_reg;
        b_e     = col_reg + CW'(1);
        b_kw    = bll_pkg::KW_ZERO;
        b_err   = bll_pkg::ERR_NONE;

        // token closed or error raised by the current mode
        if (is_eol) begin
            case (mode_reg)
                bll_pkg::MODE_ZERO, bll_pkg::MODE_DEC, bll_pkg::MODE_HEX,
                bll_pkg::MODE_BIN: begin
                    a_valid = 1'b1; a_tok = 1'b1;
                end
                bll_pkg::MODE_IDENT: begin
                    a_valid = 1'b1; a_tok = 1'b1;
                    a_kind  = kw_hit ? bll_pkg::KIND_KW : bll_pkg::KIND_VAR;
                    a_kw    = kw_hit ? kw_idx : bll_pkg::KW_ZERO;
                end
                bll_pkg::MODE_OPER: begin
                    a_valid = 1'b1; a_tok = 1'b1;
                    a_kind  = bll_pkg::single_op_kind(pend_reg);
                    a_e     = start_reg + CW'(1);
                end
                bll_pkg::MODE_STR: begin
                    a_valid = 1'b1; a_fail = 1'b1;
                    a_kind  = bll_pkg::KIND_ERR;
                    a_err   = bll_pkg::ERR_UNTERM;
                end
                bll_pkg::MODE_HEXPRE, bll_pkg::MODE_BINPRE: begin
                    a_valid = 1'b1; a_fail = 1'b1;
                    a_kind  = bll_pkg::KIND_ERR;
                    a_err   = bll_pkg::ERR_INVALID;
                    a_s     = col_reg;
                    a_e     = col_reg + CW'(1);
                end
                default: ;
            endcase
        end else if (mode_reg == bll_pkg::MODE_SKIP) begin
            // rest of the line is dropped
        end else if (col_reg >= CW'(LINE_LEN - 1)) begin
            a_valid = 1'b1; a_fail = 1'b1;
            a_kind  = bll_pkg::KIND_ERR;
            a_err   = bll_pkg::ERR_LONG;
            a_s     = col_reg;
            a_e     = col_reg + CW'(1);
        end else begin
            case (mode_reg)
                bll_pkg::MODE_COMMENT: ;
                bll_pkg::MODE_STR: begin
                    if (char_in == bll_pkg::CH_QUOTE) begin
                        a_valid = 1'b1; a_tok = 1'b1; go_idle = 1'b1;
                        a_kind  = bll_pkg::KIND_STR;
                        a_s     = start_reg + CW'(1);
                    end
                end
                bll_pkg::MODE_ZERO: begin
                    if (char_in inside {"x", "X"}) begin
                        mode_next = bll_pkg::MODE_HEXPRE;
                    end else if (char_in inside {"b", "B"}) begin
                        mode_next = bll_pkg::MODE_BINPRE;
                    end else if (bll_pkg::is_digit(char_in)) begin
                        mode_next = bll_pkg::MODE_DEC;
                    end else begin
                        a_valid = 1'b1; a_tok = 1'b1; pass_on = 1'b1;
                    end
                end
                bll_pkg::MODE_HEXPRE, bll_pkg::MODE_BINPRE: begin
                    if (mode_reg == bll_pkg::MODE_HEXPRE ? bll_pkg::is_hex(char_in)
                                                        : char_in inside {"0", "1"}) begin
                        mode_next = (mode_reg == bll_pkg::MODE_HEXPRE) ? bll_pkg::MODE_HEX
                                                                       : bll_pkg::MODE_BIN;
                    end else begin
                        a_valid = 1'b1; a_fail = 1'b1;
                        a_kind  = bll_pkg::KIND_ERR;
                        a_err   = bll_pkg::ERR_INVALID;
                        a_s     = col_reg;
                        a_e     = col_reg + CW'(1);
                    end
                end
                bll_pkg::MODE_HEX, bll_pkg::MODE_BIN, bll_pkg::MODE_DEC: begin
                    if (!((mode_reg == bll_pkg::MODE_HEX && bll_pkg::is_hex(char_in)) ||
                          (mode_reg == bll_pkg::MODE_BIN && char_in inside {"0", "1"}) ||
                          (mode_reg == bll_pkg::MODE_DEC && bll_pkg::is_digit(char_in)))) begin
                        a_valid = 1'b1; a_tok = 1'b1; pass_on = 1'b1;
                    end
                end
                bll_pkg::MODE_IDENT: begin
                    if (bll_pkg::is_alpha(char_in) || bll_pkg::is_digit(char_in)) begin
                        cand_next = narrow(cand_reg, id_len, char_in);
                    end else if (char_in == bll_pkg::CH_COLON && !kw_hit) begin
                        a_valid = 1'b1; a_tok = 1'b1; go_idle = 1'b1;
                        a_kind  = bll_pkg::KIND_LABEL;
                    end else begin
                        a_valid = 1'b1; a_tok = 1'b1; pass_on = 1'b1;
                        a_kind  = kw_hit ? bll_pkg::KIND_KW : bll_pkg::KIND_VAR;
                        a_kw    = kw_hit ? kw_idx : bll_pkg::KW_ZERO;
                    end
                end
                bll_pkg::MODE_OPER: begin
                    a_valid = 1'b1; a_tok = 1'b1;
                    if (char_in == pend_reg) begin
                        go_idle = 1'b1;
                        a_kind  = bll_pkg::KIND_OP;
                        a_e     = col_reg + CW'(1);
                    end else begin
                        pass_on = 1'b1;
                        a_kind  = bll_pkg::single_op_kind(pend_reg);
                        a_e     = start_reg + CW'(1);
                    end
                end
                default: pass_on = 1'b1;
            endcase
        end

        // token limit on the first result
        cnt_a = cnt_reg;
        if (a_tok) begin
            if (cnt_full) begin
                a_kind  = bll_pkg::KIND_ERR;
                a_err   = bll_pkg::ERR_COUNT;
                a_kw    = bll_pkg::KW_ZERO;
                a_fail  = 1'b1;
                pass_on = 1'b0;
                go_idle = 1'b0;
            end else begin
                cnt_a = cnt_reg + TW'(1);
            end
        end
        if (a_fail) begin
            mode_next = bll_pkg::MODE_SKIP;
        end else if (go_idle) begin
            mode_next = bll_pkg::MODE_IDLE;
        end
        cnt_next   = cnt_a;
        cnt_a_full = cnt_a >= TW'(MAX_TOKENS);

        // character starts something new
        if (pass_on) begin
            mode_next  = bll_pkg::MODE_IDLE;
            start_next = col_reg;
            if (char_in inside {bll_pkg::CH_SPACE, bll_pkg::CH_TAB, bll_pkg::CH_CR}) begin
                // white space
            end else if (char_in == bll_pkg::CH_HASH) begin
                mode_next = bll_pkg::MODE_COMMENT;
            end else if (bll_pkg::is_digit(char_in)) begin
                mode_next = (char_in == "0") ? bll_pkg::MODE_ZERO : bll_pkg::MODE_DEC;
            end else if (char_in == bll_pkg::CH_QUOTE) begin
                mode_next = bll_pkg::MODE_STR;
            end else if (char_in inside {"=", "&", "|"}) begin
                mode_next = bll_pkg::MODE_OPER;
                pend_next = char_in;
            end else if (bll_pkg::is_op(char_in)) begin
                b_valid = 1'b1; b_tok = 1'b1;
                b_kind  = bll_pkg::single_op_kind(char_in);
            end else if (bll_pkg::is_alpha(char_in)) begin
                mode_next = bll_pkg::MODE_IDENT;
                cand_next = narrow(bll_pkg::KW_ALL, CW'(0), char_in);
            end else begin
                b_valid   = 1'b1;
                b_kind    = bll_pkg::KIND_ERR;
                b_err     = bll_pkg::ERR_INVALID;
                mode_next = bll_pkg::MODE_SKIP;
            end
            if (b_tok) begin
                if (cnt_a_full) begin
                    b_kind    = bll_pkg::KIND_ERR;
                    b_err     = bll_pkg::ERR_COUNT;
                    mode_next = bll_pkg::MODE_SKIP;
                end else begin
                    cnt_next = cnt_a + TW'(1);
                end
            end
        end

        if (is_eol) begin
            b_valid    = 1'b1;
            b_kind     = bll_pkg::KIND_EOL;
            b_s        = col_reg;
            b_e        = col_reg;
            mode_next  = bll_pkg::MODE_IDLE;
            col_next   = '0;
            start_next = '0;
            cand_next  = bll_pkg::KW_ALL;
            pend_next  = '0;
            cnt_next   = '0;
        end else if (mode_next != bll_pkg::MODE_SKIP && col_reg < CW'(LINE_LEN)) begin
            col_next = col_reg + CW'(1);
        end

        res_a = make_res(a_kind, a_s, a_e, a_kw, a_err);
        res_b = make_res(b_kind, b_s, b_e, b_kw, b_err);
        push.first  = res_a;
        push.second = res_b;
        push.count  = {1'b0, a_valid} + {1'b0, b_valid};
        if (a_valid && b_valid) begin
            push.second.last = 1'b1;
        end else if (b_valid) begin
            push.first      = res_b;
            push.first.last = 1'b1;
        end else begin
            push.first.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bll_pkg::MODE_IDLE;
            col_reg   <= '0;
            start_reg <= '0;
            cand_reg  <= bll_pkg::KW_ALL;
            pend_reg  <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            cand_reg  <= cand_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/basic_line_lexer_unit.sv */
// basic_line_lexer_unit: streaming BASIC line tokenizer, one character in, up to two tokens out
// depends on bll_pkg and bll_core
//
//   channel   direction   ports                                             request
//   s_        in          s_valid s_ready s_char_in                         one source byte
//   m_        out         m_valid m_ready m_token_kind m_start_col          one token
//                         m_end_col m_keyword_index m_error_code m_last
//
// one character is accepted per cycle while s_ready is high; its tokens are in the result queue the next cycle
// a character gives zero, one or two tokens; the four-entry queue drains one per cycle while m_ready is high
// s_ready is low only while fewer than two queue entries are free
// synchronous reset returns the lexer to the start of a line and empties the queue
module basic_line_lexer_unit #(
    parameter int LINE_LEN   = 256,
    parameter int MAX_TOKENS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [8:0] m_start_col,
    output logic [8:0] m_end_col,
    output logic [3:0] m_keyword_index,
    output logic [2:0] m_error_code,
    output logic       m_last
);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    bll_pkg::push_t   core_push;
    bll_pkg::result_t queue_reg [QUEUE_DEPTH];
    bll_pkg::result_t head;
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]     fill_reg, fill_next;
    logic [QPW:0]     push_n;
    logic             take, pop;

    // request accepted only with room for the worst case of two tokens
    assign s_ready = fill_reg <= (QPW+1)'(QUEUE_DEPTH - 2);
    assign take    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // per-character lexer, state advances on each accepted byte
    bll_core #(
        .LINE_LEN   (LINE_LEN),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .char_in (s_char_in),
        .push    (core_push)
    );

    assign push_n    = take ? (QPW+1)'(core_push.count) : '0;
    assign fill_next = fill_reg + push_n - (QPW+1)'(pop);

    // result queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (take && core_push.count != 2'd0) begin
            queue_reg[wr_ptr_reg] <= core_push.first;
        end
        if (take && core_push.count == 2'd2) begin
            queue_reg[wr_ptr_reg + QPW'(1)] <= core_push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPW'(pop);
            fill_reg   <= fill_next;
        end
    end

    // head of queue drives the result ports
    assign head            = queue_reg[rd_ptr_reg];
    assign m_valid         = fill_reg != '0;
    assign m_token_kind    = head.kind;
    assign m_start_col     = head.start_col;
    assign m_end_col       = head.end_col;
    assign m_keyword_index = head.keyword_index;
    assign m_error_code    = head.error_code;
    assign m_last          = head.last;

    // queue never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (QPW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // a line end always produces at least the end-of-line token
    a_eol_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (s_char_in == bll_pkg::CH_NL || s_char_in == bll_pkg::CH_NUL)
        |-> core_push.count != 2'd0)
        else $error("line end produced no token");

    // error code only on error tokens
    a_err_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != bll_pkg::KIND_ERR |-> m_error_code == bll_pkg::ERR_NONE)
        else $error("error code on non-error token");

    // end-of-line token closes its character
    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == bll_pkg::KIND_EOL |-> m_last)
        else $error("end-of-line token not marked last");

endmodule

/* test/tb_basic_line_lexer_unit.sv */
// tb_basic_line_lexer_unit: self-checking bench for the BASIC line lexer, one character per request
// keeps its own lexer model and token scoreboard; needs bll_pkg and basic_line_lexer_unit
module tb_basic_line_lexer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bll_pkg::*;

    localparam int LINE_LEN     = 256;
    localparam int MAX_TOKENS   = 64;
    localparam int STIM_ITEMS   = 1100;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // character sets for building source lines
    localparam string DEC_DIGITS = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string LETTERS    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    localparam string WORD_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    localparam string OP_CHARS   = "()[]=+-*/:&|!,";
    localparam string PLAIN_OPS  = "()[]+-*/!,";

    // scoreboard: runs its own copy of the lexer on every accepted character and
    // holds the tokens still owed by the block, oldest first
    class token_checker;
        lex_mode_t   mode;
        int unsigned col;
        int unsigned tok_start;
        int unsigned tok_cnt;
        logic [8:0]  kw_mask;
        logic [7:0]  pend_op;
        int unsigned live_chars;
        int unsigned errors;
        result_t     char_tokens[$];
        result_t     expected_tokens[$];
        string       kw_word[KW_COUNT];

        function new();
            kw_word = '{"PRINT", "VAR", "INT8", "UINT8", "IF", "THEN", "ELSE", "END",
                        "MEMPEEK"};
            live_chars = 0;
            errors     = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = MODE_IDLE;
            col       = 0;
            tok_start = 0;
            tok_cnt   = 0;
            kw_mask   = KW_ALL;
            pend_op   = CH_NUL;
        endfunction

        function bit digit_char(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter_char(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        endfunction

        function bit hex_char(logic [7:0] c);
            return digit_char(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
        endfunction

        function bit op_char(logic [7:0] c);
            case (c)
                "(", ")", "[", "]", "=", "+", "-", "*", "/", ":", "&", "|", "!", ",":
                    return 1'b1;
                default:
                    return 1'b0;
            endcase
        endfunction

        function void put(token_kind_t kind, int unsigned s, int unsigned e,
                          logic [3:0] kw, error_code_t code);
            result_t r;
            r.kind          = kind;
            r.start_col     = 9'(s);
            r.end_col       = 9'(e);
            r.keyword_index = kw;
            r.error_code    = code;
            r.last          = 1'b0;
            char_tokens.push_back(r);
        endfunction

        // error token, then the rest of the line is dropped
        function void fail(error_code_t code, int unsigned s, int unsigned e);
            put(KIND_ERR, s, e, KW_ZERO, code);
            mode = MODE_SKIP;
        endfunction

        // counted token; past the per-line limit it turns into an error
        function bit count_token(token_kind_t kind, int unsigned s, int unsigned e,
                                 logic [3:0] kw);
            if (tok_cnt >= MAX_TOKENS) begin
                fail(ERR_COUNT, s, e);
                return 1'b0;
            end
            tok_cnt++;
            put(kind, s, e, kw, ERR_NONE);
            return 1'b1;
        endfunction

        function logic [8:0] narrow(logic [8:0] mask, int unsigned pos, logic [7:0] c);
            for (int k = 0; k < KW_COUNT; k++) begin
                if (pos >= kw_word[k].len() || kw_word[k][pos] != c)
                    mask[k] = 1'b0;
            end
            return mask;
        endfunction

        function int kw_hit();
            int unsigned len;
            len = col - tok_start;
            for (int k = 0; k < KW_COUNT; k++) begin
                if (kw_mask[k] && kw_word[k].len() == len)
                    return k;
            end
            return KW_COUNT;
        endfunction

        function void emit_word();
            int k;
            k = kw_hit();
            if (k < KW_COUNT)
                void'(count_token(KIND_KW, tok_start, col, 4'(k)));
            else
                void'(count_token(KIND_VAR, tok_start, col, KW_ZERO));
        endfunction

        function void emit_op(logic [7:0] c, int unsigned s);
            token_kind_t op_kind;
            case (c)
                CH_PLUS:  op_kind = KIND_PLUS;
                CH_COMMA: op_kind = KIND_COMMA;
                CH_LBRK:  op_kind = KIND_OPEN;
                CH_RBRK:  op_kind = KIND_CLOSE;
                default:  op_kind = KIND_OP;
            endcase
            void'(count_token(op_kind, s, s + 1, KW_ZERO));
        endfunction

        // a character seen between tokens
        function void begin_char(logic [7:0] c);
            mode      = MODE_IDLE;
            tok_start = col;
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                mode = MODE_IDLE;
            end else if (c == CH_HASH) begin
                mode = MODE_COMMENT;
            end else if (digit_char(c)) begin
                mode = (c == "0") ? MODE_ZERO : MODE_DEC;
            end else if (c == CH_QUOTE) begin
                mode = MODE_STR;
            end else if (op_char(c)) begin
                if (c == CH_EQ || c == CH_AMP || c == CH_BAR) begin
                    mode    = MODE_OPER;
                    pend_op = c;
                end else begin
                    emit_op(c, col);
                end
            end else if (letter_char(c)) begin
                mode    = MODE_IDENT;
                kw_mask = narrow(KW_ALL, 0, c);
            end else begin
                fail(ERR_INVALID, col, col + 1);
            end
        endfunction

        // accepted character: advance the model and queue the tokens it owes
        function void note_char(logic [7:0] c);
            bit carry;
            bit more;
            carry = 1'b0;
            char_tokens.delete();
            if (c == CH_NL || c == CH_NUL || mode != MODE_SKIP)
                live_chars++;

            if (c == CH_NL || c == CH_NUL) begin
                case (mode)
                    MODE_ZERO, MODE_DEC, MODE_HEX, MODE_BIN:
                        void'(count_token(KIND_NUM, tok_start, col, KW_ZERO));
                    MODE_IDENT:  emit_word();
                    MODE_OPER:   emit_op(pend_op, tok_start);
                    MODE_STR:    fail(ERR_UNTERM, tok_start, col);
                    MODE_HEXPRE, MODE_BINPRE: fail(ERR_INVALID, col, col + 1);
                    default: ;
                endcase
                put(KIND_EOL, col, col, KW_ZERO, ERR_NONE);
                clear_line();
            end else if (mode == MODE_SKIP) begin
                // dropped until the line ends
            end else if (col + 1 >= LINE_LEN) begin
                fail(ERR_LONG, col, col + 1);
            end else begin
                case (mode)
                    MODE_COMMENT: ;
                    MODE_STR: begin
                        if (c == CH_QUOTE) begin
                            if (count_token(KIND_STR, tok_start + 1, col, KW_ZERO))
                                mode = MODE_IDLE;
                        end
                    end
                    MODE_ZERO: begin
                        if (c == "x" || c == "X")
                            mode = MODE_HEXPRE;
                        else if (c == "b" || c == "B")
                            mode = MODE_BINPRE;
                        else if (digit_char(c))
                            mode = MODE_DEC;
                        else if (count_token(KIND_NUM, tok_start, col, KW_ZERO))
                            carry = 1'b1;
                    end
                    MODE_HEXPRE: begin
                        if (hex_char(c))
                            mode = MODE_HEX;
                        else
                            fail(ERR_INVALID, col, col + 1);
                    end
                    MODE_BINPRE: begin
                        if (c == "0" || c == "1")
                            mode = MODE_BIN;
                        else
                            fail(ERR_INVALID, col, col + 1);
                    end
                    MODE_HEX, MODE_BIN, MODE_DEC: begin
                        if (mode == MODE_HEX)
                            more = hex_char(c);
                        else if (mode == MODE_BIN)
                            more = (c == "0" || c == "1");
                        else
                            more = digit_char(c);
                        if (!more) begin
                            if (count_token(KIND_NUM, tok_start, col, KW_ZERO))
                                carry = 1'b1;
                        end
                    end
                    MODE_IDENT: begin
                        if (letter_char(c) || digit_char(c)) begin
                            kw_mask = narrow(kw_mask, col - tok_start, c);
                        end else if (c == CH_COLON && kw_hit() == KW_COUNT) begin
                            if (count_token(KIND_LABEL, tok_start, col, KW_ZERO))
                                mode = MODE_IDLE;
                        end else begin
                            emit_word();
                            if (mode != MODE_SKIP)
                                carry = 1'b1;
                        end
                    end
                    MODE_OPER: begin
                        if (c == pend_op) begin
                            if (count_token(KIND_OP, tok_start, col + 1, KW_ZERO))
                                mode = MODE_IDLE;
                        end else begin
                            emit_op(pend_op, tok_start);
                            if (mode != MODE_SKIP)
                                carry = 1'b1;
                        end
                        if (mode != MODE_OPER)
                            pend_op = CH_NUL;
                    end
                    default:
                        carry = 1'b1;
                endcase
                if (carry) begin
                    pend_op = CH_NUL;
                    begin_char(c);
                end
                if (mode != MODE_SKIP && col < LINE_LEN)
                    col++;
            end

            if (char_tokens.size() > 0)
                char_tokens[char_tokens.size() - 1].last = 1'b1;
            foreach (char_tokens[i])
                expected_tokens.push_back(char_tokens[i]);
        endfunction

        function void report(string what, result_t want, result_t got, bit have_want);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("token %s at %0t", what, $time);
                if (have_want)
                    $display("  expected kind %0d cols %0d-%0d kw %0d err %0d last %0b",
                             want.kind, want.start_col, want.end_col, want.keyword_index,
                             want.error_code, want.last);
                $display("  actual   kind %0d cols %0d-%0d kw %0d err %0d last %0b",
                         got.kind, got.start_col, got.end_col, got.keyword_index,
                         got.error_code, got.last);
            end
        endfunction

        function void check_token(result_t got);
            result_t want;
            if (expected_tokens.size() == 0) begin
                report("with nothing expected", got, got, 1'b0);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.start_col !== want.start_col ||
                got.end_col !== want.end_col || got.keyword_index !== want.keyword_index ||
                got.error_code !== want.error_code || got.last !== want.last)
                report("mismatch", want, got, 1'b1);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [3:0] m_token_kind;
    logic [8:0] m_start_col;
    logic [8:0] m_end_col;
    logic [3:0] m_keyword_index;
    logic [2:0] m_error_code;
    logic       m_last;

    token_checker sb = new();

    logic [7:0]  line_buf[$];      // source line being built, sent byte by byte
    int unsigned cycle_count = 0;
    int          sink_wait   = 0;  // cycles left before m_ready rises again
    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;

    basic_line_lexer_unit #(
        .LINE_LEN   (LINE_LEN),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_start_col     (m_start_col),
        .m_end_col       (m_end_col),
        .m_keyword_index (m_keyword_index),
        .m_error_code    (m_error_code),
        .m_last          (m_last)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit, far above the slowest legal run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_basic_line_lexer_unit: done, errors");
            $finish;
        end
    end

    // token sink: checks every accepted token, then stalls a random number of
    // cycles before taking the next; now and then it switches to no stalls at all
    always @(posedge aclk) begin
        result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.kind          = token_kind_t'(m_token_kind);
                got.start_col     = m_start_col;
                got.end_col       = m_end_col;
                got.keyword_index = m_keyword_index;
                got.error_code    = error_code_t'(m_error_code);
                got.last          = m_last;
                sb.check_token(got);
                if ($urandom_range(0, 29) == 0)
                    sink_steady = !sink_steady;
                sink_wait = sink_steady ? 0 : $urandom_range(0, 19);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    // one character request; valid stays up across back-to-back requests
    task automatic send_char(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 29) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(c);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        line_buf.delete();
    endtask

    function automatic void add_text(string t);
        for (int i = 0; i < t.len(); i++)
            line_buf.push_back(t[i]);
    endfunction

    function automatic logic [7:0] pick_char(string chars);
        return chars[$urandom_range(0, chars.len() - 1)];
    endfunction

    // any byte that neither closes a string nor ends the line
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_NL);
        return c;
    endfunction

    function automatic void end_line();
        line_buf.push_back($urandom_range(0, 1) ? CH_NL : CH_NUL);
    endfunction

    function automatic void add_word();
        line_buf.push_back(pick_char(LETTERS));
        repeat ($urandom_range(0, 4)) line_buf.push_back(pick_char(WORD_CHARS));
    endfunction

    // mostly well-formed tokens with random spacing; rare stray bytes and bad prefixes
    function automatic void build_token_line();
        string kw;
        logic [7:0] c;
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 3))
                1: line_buf.push_back(CH_SPACE);
                2: line_buf.push_back(CH_TAB);
                3: line_buf.push_back(CH_CR);
                default: ;
            endcase
            kw = sb.kw_word[$urandom_range(0, KW_COUNT - 1)];
            if ($urandom_range(0, 49) == 0) begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 49) == 0) begin
                add_text("0");
                line_buf.push_back(pick_char("xXbB"));
                line_buf.push_back(text_byte());
            end else begin
                case ($urandom_range(0, 10))
                    0: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_char(DEC_DIGITS));
                    1: begin
                        add_text("0");
                        line_buf.push_back(pick_char("xX"));
                        repeat ($urandom_range(1, 3)) line_buf.push_back(pick_char(HEX_DIGITS));
                    end
                    2: begin
                        add_text("0");
                        line_buf.push_back(pick_char("bB"));
                        repeat ($urandom_range(1, 4)) line_buf.push_back(pick_char("01"));
                    end
                    3: begin
                        line_buf.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 5)) line_buf.push_back(text_byte());
                        line_buf.push_back(CH_QUOTE);
                    end
                    4: add_text(kw);
                    5: begin
                        // near misses: keyword with a tail, or cut short
                        if ($urandom_range(0, 1))
                            add_text({kw, "1"});
                        else
                            add_text(kw.substr(0, kw.len() - 2));
                    end
                    6: add_word();
                    7: begin
                        add_word();
                        line_buf.push_back(CH_COLON);
                    end
                    8: begin
                        add_text(kw);
                        line_buf.push_back(CH_COLON);
                    end
                    9: line_buf.push_back(pick_char(OP_CHARS));
                    default: begin
                        c = pick_char("=&|");
                        line_buf.push_back(c);
                        line_buf.push_back(c);
                    end
                endcase
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            line_buf.push_back(CH_HASH);
            repeat ($urandom_range(0, 6)) line_buf.push_back(text_byte());
        end else if ($urandom_range(0, 7) == 0) begin
            line_buf.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) line_buf.push_back(text_byte());
        end
        end_line();
    endfunction

    // single-character tokens right around the per-line token limit
    function automatic void build_crowded_line();
        repeat ($urandom_range(MAX_TOKENS - 1, MAX_TOKENS + 3))
            line_buf.push_back(pick_char(PLAIN_OPS));
        end_line();
    endfunction

    // runs past the line length inside a comment, a string or an identifier
    function automatic void build_long_line();
        int shape;
        shape = $urandom_range(0, 2);
        case (shape)
            0: line_buf.push_back(CH_HASH);
            1: line_buf.push_back(CH_QUOTE);
            default: line_buf.push_back(pick_char(LETTERS));
        endcase
        repeat (LINE_LEN + 2) begin
            if (shape == 2)
                line_buf.push_back(pick_char(WORD_CHARS));
            else
                line_buf.push_back(text_byte());
        end
        end_line();
    endfunction

    initial begin : stimulus
        int unsigned line_no;
        int unsigned roll;
        line_no = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keyword before ':', hex, ==, variable, &&, string
        add_text("END:0x1F==a&&\"s\"");
        line_buf.push_back(CH_NL);
        send_line();
        // label, lone '|' cut by a digit, comma, bracket, bad binary prefix, ignored tail
        add_text("q:|1,[0b]\"u");
        line_buf.push_back(CH_NUL);
        send_line();
        // top byte is not a valid character
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_NL);
        send_line();

        while (sb.live_chars < STIM_ITEMS) begin
            roll = $urandom_range(0, 59);
            if (line_no == 2 || roll == 0)
                build_crowded_line();
            else if (line_no == 5 || roll == 1)
                build_long_line();
            else
                build_token_line();
            send_line();
            line_no++;
        end
        s_valid <= 1'b0;

        // let the token queue drain, then a short quiet spell for stray tokens
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("tb_basic_line_lexer_unit: done, clean");
        end else begin
            $display("tb_basic_line_lexer_unit: done, errors");
        end
        $finish;
    end

endmodule
